/* src/msct_pkg.sv */
// marching squares triangulator package: point ids and case tables
// no dependencies
`default_nettype none
package msct_pkg;
	typedef enum logic [2:0] {
		P_TL = 3'd0, P_TR = 3'd1, P_BR = 3'd2, P_BL = 3'd3,
		P_CT = 3'd4, P_CR = 3'd5, P_CB = 3'd6, P_CL = 3'd7
	} point_id_t;

	localparam int MaxVerts = 12;

	function automatic logic [3:0] case_count(input logic [3:0] sel);
		logic [3:0] n;
		unique case (sel)
			4'd0: n = 4'd0;
			4'd1, 4'd2, 4'd4, 4'd8: n = 4'd3;
			4'd3, 4'd6, 4'd9, 4'd12, 4'd15: n = 4'd6;
			4'd5, 4'd10: n = 4'd12;
			default: n = 4'd9;
		endcase
		return n;
	endfunction

	// unused slots of a list are padded with P_TL
	function automatic point_id_t case_point(input logic [3:0] sel, input logic [3:0] k);
		point_id_t l [12];
		unique case (sel)
			4'd0: l = '{default: P_TL};
			4'd1: l = '{P_CL, P_CB, P_BL, P_TL, P_TL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd2: l = '{P_CR, P_BR, P_CB, P_TL, P_TL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd3: l = '{P_CR, P_BR, P_BL, P_BL, P_CL, P_CR, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd4: l = '{P_CT, P_TR, P_CR, P_TL, P_TL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd5: l = '{P_CT, P_TR, P_CR, P_CT, P_CR, P_CB, P_CT, P_CB, P_BL,
				P_CT, P_BL, P_CL};
			4'd6: l = '{P_CT, P_TR, P_BR, P_CB, P_CT, P_BR, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd7: l = '{P_CT, P_TR, P_BR, P_CT, P_BR, P_BL, P_CT, P_BL, P_CL,
				P_TL, P_TL, P_TL};
			4'd8: l = '{P_TL, P_CT, P_CL, P_TL, P_TL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd9: l = '{P_TL, P_CT, P_CB, P_CB, P_BL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd10: l = '{P_TL, P_CT, P_CR, P_TL, P_CR, P_BR, P_TL, P_BR, P_CB,
				P_TL, P_CB, P_CL};
			4'd11: l = '{P_TL, P_CT, P_CR, P_TL, P_CR, P_BR, P_TL, P_BR, P_BL,
				P_TL, P_TL, P_TL};
			4'd12: l = '{P_TL, P_TR, P_CR, P_CR, P_CL, P_TL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
			4'd13: l = '{P_TL, P_TR, P_CR, P_TL, P_CR, P_CB, P_TL, P_CB, P_BL,
				P_TL, P_TL, P_TL};
			4'd14: l = '{P_TL, P_TR, P_BR, P_TL, P_BR, P_CB, P_TL, P_CB, P_CL,
				P_TL, P_TL, P_TL};
			4'd15: l = '{P_TL, P_TR, P_BR, P_TL, P_BR, P_BL, P_TL, P_TL, P_TL,
				P_TL, P_TL, P_TL};
		endcase
		return (k < 4'd12) ? l[k] : P_TL;
	endfunction
endpackage
`default_nettype wire

/* src/marching_squares_cell_triangulator_unit.sv */
// top level of the marching squares cell triangulator
// depends on msct_pkg, msct_front, msct_back
//
// channel | signals                               | direction
// in      | in_valid, in_stall, cell/point fields | into block
// out     | out_valid, out_stall, vertex fields   | out of block
//
// a cell goes from its input beat to the hand-off through the bit-serial dividers,
// which run the four crossings in parallel; in_stall stays high until the hand-off,
// so a new cell is accepted only after the last one has been handed off
// the back end emits one vertex beat per cycle unless out_stall holds a pending vertex, 0 to 12 per cell
// a one-cell hand-off register lets the front work on the next cell while
// the back still emits; out_stall holds the current vertex
// reset clears all control state; payload registers are not reset
`default_nettype none
module marching_squares_cell_triangulator_unit #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [COORD_BITS-1:0] cell_bottom_y,
	input  wire logic signed [COORD_BITS-1:0] cell_top_y,
	input  wire logic signed [COORD_BITS-1:0] left_point_x,
	input  wire logic signed [COORD_BITS-1:0] left_point_y,
	input  wire logic signed [COORD_BITS-1:0] right_point_x,
	input  wire logic signed [COORD_BITS-1:0] right_point_y,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic last_vertex
);
	// ratio is dimensionless, so the fraction width does not enter the datapath
	localparam int W = COORD_BITS + 0 * FRAC_BITS;

	logic cell_valid, cell_take;
	logic [3:0] cell_sel;
	logic signed [W-1:0] cell_px [8];
	logic signed [W-1:0] cell_py [8];

	msct_front #(.W(W)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.g0(cell_bottom_y), .g1(cell_top_y), .lx(left_point_x), .ly(left_point_y),
		.rx(right_point_x), .ry(right_point_y),
		.cell_valid, .cell_take, .cell_sel, .cell_px, .cell_py
	);

	msct_back #(.W(W)) u_back (
		.clk, .arst_n, .cell_valid, .cell_take, .cell_sel, .cell_px, .cell_py,
		.out_valid, .out_stall, .vx(vertex_x), .vy(vertex_y), .last(last_vertex)
	);
endmodule
`default_nettype wire

/* src/msct_muldiv.sv */
// sequential start + span*num/den unit: a multiply step, then restoring division
// depends on nothing but its parameters
`default_nettype none
module msct_muldiv #(
	parameter int W = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [W-1:0] base,
	input  wire logic signed [W:0] span,
	input  wire logic signed [W:0] num,
	input  wire logic signed [W+1:0] den,
	output logic busy,
	output logic signed [W-1:0] result
);
	localparam int MW = W + 1;
	localparam int PW = 2 * MW;
	localparam int CW = $clog2(PW + 1);

	logic [MW-1:0] m_q, t_q;
	logic [MW:0] d_q;
	logic [PW-1:0] p_q;
	logic [MW+1:0] r_q;
	logic [PW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, zero_q, mul_q;
	logic signed [W-1:0] base_q;

	logic [MW-1:0] sm, nm, tm;
	logic [MW:0] dm;
	logic [MW+1:0] rsh, rsub;
	logic signed [W+2:0] sum;
	logic signed [W-1:0] hi, lo;

	always_comb begin
		sm = span[W] ? MW'(-span) : MW'(span);
		nm = num[W] ? MW'(-num) : MW'(num);
		dm = den[W+1] ? (MW+1)'(-den) : (MW+1)'(den);
		tm = ({1'b0, nm} > dm) ? MW'(dm) : nm;
		rsh = {r_q[MW:0], p_q[PW-1]};
		rsub = rsh - {1'b0, d_q};
		hi = {1'b0, {(W-1){1'b1}}};
		lo = {1'b1, {(W-1){1'b0}}};
		sum = neg_q ? ((W+3)'(base_q) - (W+3)'(signed'({1'b0, q_q[MW:0]})))
			: ((W+3)'(base_q) + (W+3)'(signed'({1'b0, q_q[MW:0]})));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
			mul_q <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
			mul_q <= 1'b1;
			cnt_q <= CW'(PW);
			m_q <= sm;
			t_q <= tm;
			d_q <= dm;
			base_q <= base;
			zero_q <= (den == '0);
			neg_q <= (span != '0) && (num != '0) && ((span[W] ^ num[W]) ^ den[W+1]);
			r_q <= '0;
			q_q <= '0;
		end else if (busy) begin
			if (mul_q) begin
				mul_q <= 1'b0;
				p_q <= PW'(m_q * t_q);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				p_q <= p_q << 1;
				if (!rsub[MW+1]) begin
					r_q <= rsub;
					q_q <= {q_q[PW-2:0], 1'b1};
				end else begin
					r_q <= rsh;
					q_q <= {q_q[PW-2:0], 1'b0};
				end
			end else begin
				busy <= 1'b0;
				if (zero_q) result <= base_q;
				else if (sum > (W+3)'(hi)) result <= hi;
				else if (sum < (W+3)'(lo)) result <= lo;
				else result <= W'(sum);
			end
		end
	end
endmodule
`default_nettype wire

/* src/msct_front.sv */
// front end: classifies a cell and computes the four crossings
// depends on msct_pkg and msct_muldiv
`default_nettype none
module msct_front #(
	parameter int W = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [W-1:0] g0, g1, lx, ly, rx, ry,
	output logic cell_valid,
	input  wire logic cell_take,
	output logic [3:0] cell_sel,
	output logic signed [W-1:0] cell_px [8],
	output logic signed [W-1:0] cell_py [8]
);
	import msct_pkg::*;

	logic signed [W-1:0] g0_q, g1_q, lx_q, ly_q, rx_q, ry_q;
	logic busy_q, started_q;
	logic signed [W:0] a, b, c, d, sx, sy;
	logic [3:0] busy_u;
	logic signed [W-1:0] ct, cr, cb, cl;
	logic full_q;

	always_comb begin
		a = (W+1)'(g1_q) - (W+1)'(ly_q);
		b = (W+1)'(g1_q) - (W+1)'(ry_q);
		d = (W+1)'(g0_q) - (W+1)'(ry_q);
		c = (W+1)'(g0_q) - (W+1)'(ly_q);
		sx = (W+1)'(rx_q) - (W+1)'(lx_q);
		sy = (W+1)'(g0_q) - (W+1)'(g1_q);
	end

	msct_muldiv #(.W(W)) u_ct (.clk, .arst_n, .start(started_q), .base(lx_q), .span(sx),
		.num(-a), .den((W+2)'(b) - (W+2)'(a)), .busy(busy_u[0]), .result(ct));
	msct_muldiv #(.W(W)) u_cr (.clk, .arst_n, .start(started_q), .base(g1_q), .span(sy),
		.num(-b), .den((W+2)'(d) - (W+2)'(b)), .busy(busy_u[1]), .result(cr));
	msct_muldiv #(.W(W)) u_cb (.clk, .arst_n, .start(started_q), .base(lx_q), .span(sx),
		.num(-c), .den((W+2)'(d) - (W+2)'(c)), .busy(busy_u[2]), .result(cb));
	msct_muldiv #(.W(W)) u_cl (.clk, .arst_n, .start(started_q), .base(g1_q), .span(sy),
		.num(-a), .den((W+2)'(c) - (W+2)'(a)), .busy(busy_u[3]), .result(cl));

	assign in_stall = busy_q;
	wire done = busy_q && !started_q && (busy_u == 4'b0) && !(full_q && !cell_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			started_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			started_q <= in_valid && !busy_q;
			if (done) full_q <= 1'b1;
			else if (cell_take) full_q <= 1'b0;
			if (in_valid && !busy_q) begin
				busy_q <= 1'b1;
				g0_q <= g0; g1_q <= g1; lx_q <= lx; ly_q <= ly; rx_q <= rx; ry_q <= ry;
			end else if (done) begin
				busy_q <= 1'b0;
				cell_sel <= {a <= 0, b <= 0, d <= 0, c <= 0};
				cell_px <= '{lx_q, rx_q, rx_q, lx_q, ct, rx_q, cb, lx_q};
				cell_py <= '{g1_q, g1_q, g0_q, g0_q, g1_q, cr, g0_q, cl};
			end
		end
	end
	assign cell_valid = full_q;
endmodule
`default_nettype wire

/* src/msct_back.sv */
// back end: walks the case list and emits one vertex per beat
// depends on msct_pkg
`default_nettype none
module msct_back #(
	parameter int W = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cell_valid,
	output logic cell_take,
	input  wire logic [3:0] cell_sel,
	input  wire logic signed [W-1:0] cell_px [8],
	input  wire logic signed [W-1:0] cell_py [8],
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [W-1:0] vx,
	output logic signed [W-1:0] vy,
	output logic last
);
	import msct_pkg::*;

	logic active_q;
	logic [3:0] sel_q, k_q, n_q;
	logic signed [W-1:0] px_q [8];
	logic signed [W-1:0] py_q [8];
	logic ov_q;
	point_id_t id;
	wire slot_free = !ov_q || !out_stall;

	assign cell_take = cell_valid && !active_q;
	assign id = case_point(sel_q, k_q);
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ov_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cell_take) begin
				ov_q <= ov_q && out_stall;
				sel_q <= cell_sel;
				n_q <= case_count(cell_sel);
				k_q <= '0;
				px_q <= cell_px;
				py_q <= cell_py;
				active_q <= (case_count(cell_sel) != 4'd0);
			end else if (active_q && slot_free) begin
				ov_q <= 1'b1;
				vx <= px_q[id];
				vy <= py_q[id];
				last <= (k_q == n_q - 4'd1);
				k_q <= k_q + 4'd1;
				if (k_q == n_q - 4'd1) active_q <= 1'b0;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
